// File: hdl/signed_int_to_decimal_ascii_assert.svh
// Assertion macros for the signed integer to decimal text converter.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// same-cycle implication
`define SIDTA_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("signed_int_to_decimal_ascii: assertion failed");

// next-cycle implication
`define SIDTA_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("signed_int_to_decimal_ascii: assertion failed");

`endif

// File: hdl/sidta_pkg.sv
// Shared types and constants for the signed integer to decimal text converter.
// No dependencies.
package sidta_pkg;

    localparam int VALUE_W    = 32;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 10;
    localparam int BIT_CNT_W  = $clog2(VALUE_W);
    localparam int REM_W      = $clog2(NUM_DIGITS + 1);

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    localparam logic [DIGIT_W-1:0] DAB_LIMIT  = 4'd5;
    localparam logic [DIGIT_W-1:0] DAB_OFFSET = 4'd3;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    typedef struct packed {
        logic clear;
        logic dab;
        logic move;
    } cell_ctl_t;

endpackage

// File: hdl/sidta_cell.sv
// One decimal digit cell of the shift-and-add-3 conversion chain.
// Depends on sidta_pkg.
module sidta_cell (
    input  logic                            aclk,
    input  sidta_pkg::cell_ctl_t            ctl,
    input  logic                            carry_in,
    input  logic [sidta_pkg::DIGIT_W-1:0]   digit_in,
    output logic                            carry_out,
    output logic [sidta_pkg::DIGIT_W-1:0]   digit
);

    logic [sidta_pkg::DIGIT_W-1:0] digit_reg;
    logic [sidta_pkg::DIGIT_W-1:0] digit_next;
    logic [sidta_pkg::DIGIT_W-1:0] adj;

    assign adj       = (digit_reg >= sidta_pkg::DAB_LIMIT) ?
                       digit_reg + sidta_pkg::DAB_OFFSET : digit_reg;
    assign carry_out = adj[sidta_pkg::DIGIT_W-1];
    assign digit     = digit_reg;

    always_comb begin
        digit_next = digit_reg;
        if (ctl.clear) begin
            digit_next = '0;
        end else if (ctl.dab) begin
            digit_next = {adj[sidta_pkg::DIGIT_W-2:0], carry_in};
        end else if (ctl.move) begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
    end

endmodule

// File: hdl/signed_int_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII text. One value is taken while the block is idle;
// its magnitude then shifts, one bit per cycle, into a chain of ten BCD digit cells
// (shift and add 3). The chain then shifts towards the top cell, one digit per cycle except
// while the '-' goes out or a character waits on m_tready: leading zeros are dropped, each
// remaining digit leaves as one character, '-' goes first for a negative value, and tlast
// marks the final character.
// Depends on sidta_pkg, sidta_cell and signed_int_to_decimal_ascii_assert.svh.
`include "signed_int_to_decimal_ascii_assert.svh"

module signed_int_to_decimal_ascii (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] character
    output logic        m_tlast
);

    localparam int ND = sidta_pkg::NUM_DIGITS;
    localparam int DW = sidta_pkg::DIGIT_W;

    sidta_pkg::state_t state_reg, state_next;
    logic [sidta_pkg::VALUE_W-1:0]   mag_reg, mag_next;
    logic [sidta_pkg::BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [sidta_pkg::REM_W-1:0]     rem_reg, rem_next;
    logic                            sign_pend_reg, sign_pend_next;
    logic                            started_reg, started_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [7:0]                      m_tdata_reg, m_tdata_next;
    logic                            m_tlast_reg, m_tlast_next;

    sidta_pkg::cell_ctl_t ctl;
    logic [ND:0]                     carry;
    logic [DW-1:0]                   digits  [ND];
    logic [DW-1:0]                   din     [ND];
    logic                            s_accept;
    logic                            out_free;

    assign carry[0] = mag_reg[sidta_pkg::VALUE_W-1];
    assign din[0]   = '0;

    for (genvar i = 0; i < ND; i++) begin : g_cell
        if (i > 0) begin : g_din
            assign din[i] = digits[i-1];
        end
        sidta_cell u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .carry_in  (carry[i]),
            .digit_in  (din[i]),
            .carry_out (carry[i+1]),
            .digit     (digits[i])
        );
    end

    assign s_tready = (state_reg == sidta_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    always_comb begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        bit_cnt_next   = bit_cnt_reg;
        rem_next       = rem_reg;
        sign_pend_next = sign_pend_reg;
        started_next   = started_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tlast_next   = m_tlast_reg;
        ctl            = '0;
        case (state_reg)
            sidta_pkg::ST_IDLE: begin
                if (s_accept) begin
                    sign_pend_next = s_tdata[sidta_pkg::VALUE_W-1];
                    mag_next       = s_tdata[sidta_pkg::VALUE_W-1] ? 32'd0 - s_tdata : s_tdata;
                    bit_cnt_next   = '0;
                    ctl.clear      = 1'b1;
                    state_next     = sidta_pkg::ST_CONV;
                end
            end
            sidta_pkg::ST_CONV: begin
                ctl.dab      = 1'b1;
                mag_next     = {mag_reg[sidta_pkg::VALUE_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == sidta_pkg::BIT_CNT_W'(sidta_pkg::VALUE_W - 1)) begin
                    rem_next     = sidta_pkg::REM_W'(ND);
                    started_next = 1'b0;
                    state_next   = sidta_pkg::ST_EMIT;
                end
            end
            sidta_pkg::ST_EMIT: begin
                if (sign_pend_reg) begin
                    if (out_free) begin
                        m_tvalid_next  = 1'b1;
                        m_tdata_next   = sidta_pkg::CHAR_MINUS;
                        m_tlast_next   = 1'b0;
                        sign_pend_next = 1'b0;
                    end
                end else if (!started_reg && digits[ND-1] == '0 &&
                             rem_reg > sidta_pkg::REM_W'(1)) begin
                    ctl.move = 1'b1;
                    rem_next = rem_reg - 1'b1;
                end else if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = sidta_pkg::CHAR_ZERO + {4'b0000, digits[ND-1]};
                    m_tlast_next  = (rem_reg == sidta_pkg::REM_W'(1));
                    ctl.move      = 1'b1;
                    rem_next      = rem_reg - 1'b1;
                    started_next  = 1'b1;
                    if (rem_reg == sidta_pkg::REM_W'(1)) begin
                        state_next = sidta_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = sidta_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sidta_pkg::ST_IDLE;
            bit_cnt_reg   <= '0;
            rem_reg       <= '0;
            sign_pend_reg <= 1'b0;
            started_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            rem_reg       <= rem_next;
            sign_pend_reg <= sign_pend_next;
            started_reg   <= started_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg     <= mag_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    `SIDTA_ASSERT_NOW(a_no_digit_overflow, aclk, aresetn, state_reg == sidta_pkg::ST_CONV, !carry[ND])
    `SIDTA_ASSERT_NXT(a_accept_starts_conv, aclk, aresetn, s_accept, state_reg == sidta_pkg::ST_CONV && bit_cnt_reg == '0)
    `SIDTA_ASSERT_NOW(a_last_is_digit, aclk, aresetn, m_tvalid_reg && m_tlast_reg, m_tdata_reg >= sidta_pkg::CHAR_ZERO && m_tdata_reg <= sidta_pkg::CHAR_NINE)
    `SIDTA_ASSERT_NOW(a_idle_clean, aclk, aresetn, state_reg == sidta_pkg::ST_IDLE, !sign_pend_reg && rem_reg == '0)

endmodule
